FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the dequantizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on the rising clock edge, masked during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form, antecedent and consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication form, consequent checked in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/jbdq_pkg.sv
// Shared constants and types of the JPEG 2000 block dequantizer.
`default_nettype none

package jbdq_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned STATE_W = 8;
   localparam int unsigned MB_W    = 5;
   localparam int unsigned ROI_W   = 5;
   localparam int unsigned SCALE_W = 31;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MAGNITUDE_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_SHIFT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSIBLE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SCALE     = 2'd3;

   localparam logic [MB_W-1:0]    MB_RESET        = 5'd8;
   localparam logic [ROI_W-1:0]   ROI_RESET       = 5'd0;
   localparam logic               REVERSIBLE_RESET = 1'b1;
   localparam logic [SCALE_W-1:0] SCALE_RESET     = 31'd32768;

   localparam logic [MB_W-1:0] MB_MIN = 5'd1;
   localparam logic [MB_W-1:0] MB_MAX = 5'd30;

   // irreversible path rounding
   localparam logic [WORD_W-1:0] ROUND_16 = 32'h0000_8000;
   localparam logic [WORD_W-1:0] ROUND_15 = 32'h0000_4000;
   localparam int unsigned       SHIFT_16 = 16;
   localparam int unsigned       DOWNSHIFT = 15;

   typedef struct packed {
      logic [WORD_W-1:0] mag;
      logic              neg;
      logic [MB_W-1:0]   plsb;
   } front_type;

endpackage

`default_nettype wire

FILE: hw/rtl/jpeg2000_block_dequantizer.sv
// Top level of the JPEG 2000 block dequantizer: csr bank and four-stage pipeline.
//
// Input channel req_*: one code-block sample (sign-magnitude word) and its
// state byte per transaction, valid/ready handshake.
// Result channel rsp_*: one signed dequantized coefficient per transaction.
// csr_*: plain write port, register index and data, written on csr_wr_en.
// Registers: magnitude bits, ROI shift, reversible select, step scale.
// Write them only while the pipeline is empty.
// A sample runs through stages one to four; rsp_valid is stage four's valid.
// Throughput: one sample per cycle unless rsp_ready stalls; the stage that
// bounds timing is the 32x31 multiplier of the irreversible path in stage three.
// Each stage holds its own valid bit and advances when the next one has
// room, so bubbles close up and a stalled receiver backs the stages up
// one by one; req_ready drops only once all four stages hold data.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults: eight magnitude bits, no ROI, reversible, scale 32768.
`default_nettype none
`include "assert_macros.svh"

module jpeg2000_block_dequantizer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [jbdq_pkg::WORD_W-1:0]      req_sample_word,
   input  wire logic [jbdq_pkg::STATE_W-1:0]     req_state_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [jbdq_pkg::WORD_W-1:0]    rsp_coefficient,
   input  wire logic                             csr_wr_en,
   input  wire logic [jbdq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [jbdq_pkg::SCALE_W-1:0]     csr_wdata
);

   logic [jbdq_pkg::MB_W-1:0]    mb_ff;
   logic [jbdq_pkg::ROI_W-1:0]   roi_ff;
   logic                         rev_ff;
   logic [jbdq_pkg::SCALE_W-1:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mb_ff    <= jbdq_pkg::MB_RESET;
         roi_ff   <= jbdq_pkg::ROI_RESET;
         rev_ff   <= jbdq_pkg::REVERSIBLE_RESET;
         scale_ff <= jbdq_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            jbdq_pkg::CSR_MAGNITUDE_BITS: mb_ff    <= csr_wdata[jbdq_pkg::MB_W-1:0];
            jbdq_pkg::CSR_ROI_SHIFT:      roi_ff   <= csr_wdata[jbdq_pkg::ROI_W-1:0];
            jbdq_pkg::CSR_REVERSIBLE:     rev_ff   <= csr_wdata[0];
            jbdq_pkg::CSR_STEP_SCALE:     scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   jbdq_pkg::front_type front;

   jbdq_front u_front (
      .sample_word    (req_sample_word),
      .state_byte     (req_state_byte),
      .magnitude_bits (mb_ff),
      .roi_shift      (roi_ff),
      .reversible     (rev_ff),
      .front          (front)
   );

   // stage valids and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage 1: front-end result
   jbdq_pkg::front_type s1_ff;

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= front;
   end

   // stage 2: sign restore (reversible) or round to 16 bits (irreversible)
   logic [jbdq_pkg::WORD_W-1:0] s2_in, s2_ff;
   logic [jbdq_pkg::WORD_W-1:0] rnd16;
   logic                        neg2_ff;
   logic [jbdq_pkg::MB_W-1:0]   plsb2_ff;

   always_comb begin
      rnd16 = s1_ff.mag + jbdq_pkg::ROUND_16;
      if (rev_ff) begin
         s2_in = s1_ff.neg ? (32'd0 - s1_ff.mag) : s1_ff.mag;
      end else begin
         s2_in = $unsigned($signed(rnd16) >>> jbdq_pkg::SHIFT_16);
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_ff    <= s2_in;
         neg2_ff  <= s1_ff.neg;
         plsb2_ff <= s1_ff.plsb;
      end
   end

   // stage 3: arithmetic down-shift (reversible) or step-scale multiply
   logic [jbdq_pkg::WORD_W+jbdq_pkg::SCALE_W-1:0] prod;
   logic [jbdq_pkg::WORD_W-1:0]                   s3_in, s3_ff;
   logic                                          neg3_ff;

   always_comb begin
      prod = s2_ff * scale_ff;
      if (rev_ff) begin
         s3_in = $unsigned($signed(s2_ff) >>> plsb2_ff);
      end else begin
         s3_in = prod[jbdq_pkg::WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_ff   <= s3_in;
         neg3_ff <= neg2_ff;
      end
   end

   // stage 4: round down by 15 and restore sign (irreversible), output register
   logic [jbdq_pkg::WORD_W-1:0] rnd15;
   logic [jbdq_pkg::WORD_W-1:0] down;
   logic [jbdq_pkg::WORD_W-1:0] s4_in, s4_ff;

   always_comb begin
      rnd15 = s3_ff + jbdq_pkg::ROUND_15;
      down  = $unsigned($signed(rnd15) >>> jbdq_pkg::DOWNSHIFT);
      if (rev_ff) begin
         s4_in = s3_ff;
      end else begin
         s4_in = neg3_ff ? (32'd0 - down) : down;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) s4_ff <= s4_in;
   end

   assign rsp_coefficient = $signed(s4_ff);

   // an empty output stage means every stage can move
   `ASSERT_IMPL(a_ready_when_drained, clock, reset, !rsp_valid, req_ready, "pipeline blocked while output empty")

   // zero magnitude never gains a reconstruction bit in reversible mode
   `ASSERT_NEXT(a_zero_stays_zero, clock, reset, en2 && v1_ff && rev_ff && (s1_ff.mag == '0), s2_ff == '0, "zero sample became nonzero")

   // arithmetic down-shift keeps the sign
   `ASSERT_NEXT(a_shift_keeps_sign, clock, reset, en3 && v2_ff && rev_ff, s3_ff[31] == $past(s2_ff[31]), "down-shift changed sign")

endmodule

`default_nettype wire

FILE: hw/rtl/jbdq_front.sv
// Front end: sign split, ROI up-shift and reconstruction bit placement.
`default_nettype none

module jbdq_front (
   input  wire logic [jbdq_pkg::WORD_W-1:0]  sample_word,
   input  wire logic [jbdq_pkg::STATE_W-1:0] state_byte,
   input  wire logic [jbdq_pkg::MB_W-1:0]    magnitude_bits,
   input  wire logic [jbdq_pkg::ROI_W-1:0]   roi_shift,
   input  wire logic                         reversible,
   output jbdq_pkg::front_type               front
);

   logic [jbdq_pkg::MB_W-1:0]   mb;
   logic [jbdq_pkg::MB_W-1:0]   plsb;
   logic [jbdq_pkg::MB_W-1:0]   planes;
   logic [jbdq_pkg::MB_W-1:0]   nb;
   logic                        nb_lt;
   logic [jbdq_pkg::MB_W-1:0]   rshift;
   logic                        roi_on;
   logic                        roi_hit;
   logic [jbdq_pkg::WORD_W-1:0] mag_raw;
   logic [jbdq_pkg::WORD_W-1:0] mag_roi;
   logic                        set_rbit;

   always_comb begin
      if (magnitude_bits < jbdq_pkg::MB_MIN) begin
         mb = jbdq_pkg::MB_MIN;
      end else if (magnitude_bits > jbdq_pkg::MB_MAX) begin
         mb = jbdq_pkg::MB_MAX;
      end else begin
         mb = magnitude_bits;
      end
      plsb   = 5'd31 - mb;
      planes = state_byte[7:3];

      mag_raw = {1'b0, sample_word[30:0]};
      roi_on  = (roi_shift != '0);
      // below 2^plsb means nothing survives a right shift by plsb
      roi_hit = roi_on && ((mag_raw >> plsb) == '0);
      mag_roi = roi_hit ? (mag_raw << roi_shift) : mag_raw;

      nb    = roi_on ? mb : (5'd31 - planes);
      nb_lt = (nb < mb);
      // true value never exceeds 30, so 5-bit wrap of plsb-1 is harmless
      rshift = nb_lt ? (plsb - 5'd1 + (mb - nb)) : (plsb - 5'd1);

      set_rbit = (mag_roi != '0) && (!reversible || nb_lt);

      front.mag  = set_rbit ? (mag_roi | (32'd1 << rshift)) : mag_roi;
      front.neg  = sample_word[31];
      front.plsb = plsb;
   end

endmodule

`default_nettype wire
